/* src/shed_partial_first_event_queue_top_defines.svh */
// Assertion macros for the shed-partial-first event queue.
`ifndef SHED_PARTIAL_FIRST_EVENT_QUEUE_TOP_DEFINES_SVH
`define SHED_PARTIAL_FIRST_EVENT_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define SPEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("speq: same-cycle check failed");
// Check that a condition implies another in the next cycle.
`define SPEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("speq: next-cycle check failed");
`else
`define SPEQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define SPEQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/speq_pkg.sv */
// Shared types and codes for the shed-partial-first event queue.
package speq_pkg;

   // Fixed field widths
   localparam int PAYLOAD_W = 32;
   localparam int LENGTH_W  = 16;
   localparam int SEQ_W     = 32;
   localparam int COUNT_W   = 9;
   localparam int TOTAL_W   = 32;

   // Operation codes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_PUSH       = 2'd0;
   localparam opcode_type OP_POP        = 2'd1;
   localparam opcode_type OP_INVALIDATE = 2'd2;

   // Result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_LEN_REJECT = 2'd1;
   localparam status_type ST_EMPTY      = 2'd2;
   localparam status_type ST_OLD_SEQ    = 2'd3;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;
      logic scan_start;
      logic scan_step;
      logic shift_start;
      logic shift_step;
      logic pop_read;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic push_ok;
      logic full;
      logic pop;
      logic empty;
      logic scan_hit;
      logic scan_last;
      logic at_head;
      logic out_free;
   } stat_type;

endpackage

/* src/speq_ctrl.sv */
// Sequencer for the event queue: dispatch, victim scan, shift and finish.
module speq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  speq_pkg::stat_type  stat,
   output speq_pkg::cmd_type   cmd
);

   speq_pkg::state_type state_ff;
   speq_pkg::state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= speq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide the next state and issue commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         speq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = speq_pkg::S_DISPATCH;
            end
         end
         speq_pkg::S_DISPATCH: begin
            if (stat.push_ok && stat.full) begin
               cmd.scan_start = 1'b1;
               state_in       = speq_pkg::S_SCAN;
            end else begin
               if (stat.pop && !stat.empty) begin
                  cmd.pop_read = 1'b1;
               end
               state_in = speq_pkg::S_FINISH;
            end
         end
         speq_pkg::S_SCAN: begin
            // stop at the oldest partial entry, or fall back to the head
            if (stat.scan_hit) begin
               if (stat.at_head) begin
                  state_in = speq_pkg::S_FINISH;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = speq_pkg::S_SHIFT;
               end
            end else if (stat.scan_last) begin
               state_in = speq_pkg::S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         speq_pkg::S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.at_head) begin
               state_in = speq_pkg::S_FINISH;
            end
         end
         speq_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = speq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = speq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* src/speq_datapath.sv */
// Slot memory, queue pointers, counters and result register of the event queue.
module speq_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int LINE_LIMIT  = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  speq_pkg::cmd_type                      cmd,
   output speq_pkg::stat_type                     stat,
   input  logic [1:0]                             req_opcode,
   input  logic [speq_pkg::PAYLOAD_W-1:0]         req_payload,
   input  logic [speq_pkg::LENGTH_W-1:0]          req_line_length,
   input  logic                                   req_final_flag,
   input  logic [speq_pkg::SEQ_W-1:0]             req_sequence_req,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic [speq_pkg::PAYLOAD_W-1:0]         rsp_out_payload,
   output logic [speq_pkg::LENGTH_W-1:0]          rsp_out_length,
   output logic                                   rsp_out_final,
   output logic [speq_pkg::SEQ_W-1:0]             rsp_out_sequence,
   output logic                                   rsp_evicted,
   output logic [speq_pkg::COUNT_W-1:0]           rsp_discarded,
   output logic [speq_pkg::COUNT_W-1:0]           rsp_occupancy,
   output logic [speq_pkg::TOTAL_W-1:0]           rsp_generation,
   output logic [speq_pkg::TOTAL_W-1:0]           rsp_dropped_total,
   output logic [speq_pkg::TOTAL_W-1:0]           rsp_rejected_total
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int LEN_W = $clog2(LINE_LIMIT);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   // Slot memory, one array per field, shared address
   logic [speq_pkg::PAYLOAD_W-1:0] mem_payload  [QUEUE_DEPTH];
   logic [LEN_W-1:0]               mem_length   [QUEUE_DEPTH];
   logic                           mem_final    [QUEUE_DEPTH];
   logic [speq_pkg::SEQ_W-1:0]     mem_sequence [QUEUE_DEPTH];

   // Latched request
   speq_pkg::opcode_type           op_ff;
   logic                           len_ok_ff;
   logic [speq_pkg::PAYLOAD_W-1:0] payload_ff;
   logic [LEN_W-1:0]               length_ff;
   logic                           final_ff;
   logic [speq_pkg::SEQ_W-1:0]     seq_ff;

   // Registered read data
   logic [speq_pkg::PAYLOAD_W-1:0] rd_payload_ff;
   logic [LEN_W-1:0]               rd_length_ff;
   logic                           rd_final_ff;
   logic [speq_pkg::SEQ_W-1:0]     rd_seq_ff;

   // Walk pointers for scan and shift
   logic [IDX_W-1:0] chk_ptr_ff, chk_ptr_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             evict_ff, evict_in;

   // Queue state and counters
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [speq_pkg::TOTAL_W-1:0]   gen_ff, gen_in;
   logic [speq_pkg::SEQ_W-1:0]     last_seq_ff, last_seq_in;
   logic                           have_last_ff, have_last_in;
   logic [speq_pkg::TOTAL_W-1:0]   drop_ff, drop_in;
   logic [speq_pkg::TOTAL_W-1:0]   reject_ff, reject_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   speq_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [speq_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [speq_pkg::LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;
   logic                           rsp_final_ff, rsp_final_in;
   logic [speq_pkg::SEQ_W-1:0]     rsp_seq_ff, rsp_seq_in;
   logic                           rsp_evicted_ff, rsp_evicted_in;
   logic [speq_pkg::COUNT_W-1:0]   rsp_discarded_ff, rsp_discarded_in;
   logic [speq_pkg::COUNT_W-1:0]   rsp_occupancy_ff, rsp_occupancy_in;
   logic [speq_pkg::TOTAL_W-1:0]   rsp_gen_ff, rsp_gen_in;
   logic [speq_pkg::TOTAL_W-1:0]   rsp_drop_ff, rsp_drop_in;
   logic [speq_pkg::TOTAL_W-1:0]   rsp_reject_ff, rsp_reject_in;

   // Pointer arithmetic and memory port controls
   logic [IDX_W-1:0]               chk_next, chk_prev, head_next, tail_idx, push_idx;
   logic [SUM_W-1:0]               tail_sum;
   logic                           rd_en, we;
   logic [IDX_W-1:0]               rd_addr, wa;
   logic [speq_pkg::PAYLOAD_W-1:0] wd_payload;
   logic [LEN_W-1:0]               wd_length;
   logic                           wd_final;
   logic [speq_pkg::SEQ_W-1:0]     wd_seq;

   // Wrap pointers around the ring
   always_comb begin
      chk_next  = (chk_ptr_ff == LAST_IDX) ? '0 : chk_ptr_ff + 1'b1;
      chk_prev  = (chk_ptr_ff == '0) ? LAST_IDX : chk_ptr_ff - 1'b1;
      head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= DEPTH_SUM) begin
         tail_idx = IDX_W'(tail_sum - DEPTH_SUM);
      end else begin
         tail_idx = IDX_W'(tail_sum);
      end
      // after a shed the new entry lands in the old head slot
      push_idx = evict_ff ? head_ff : tail_idx;
   end

   // Report status to the controller
   always_comb begin
      stat.push_ok   = (op_ff == speq_pkg::OP_PUSH) && len_ok_ff;
      stat.full      = (count_ff == DEPTH_CNT);
      stat.pop       = (op_ff == speq_pkg::OP_POP);
      stat.empty     = (count_ff == '0);
      stat.scan_hit  = !rd_final_ff;
      stat.scan_last = (k_ff == LAST_IDX);
      stat.at_head   = (chk_ptr_ff == head_ff);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Select memory read and write ports
   always_comb begin
      rd_en = cmd.scan_start | cmd.scan_step | cmd.pop_read
            | cmd.shift_start | cmd.shift_step;
      if (cmd.scan_start || cmd.pop_read) begin
         rd_addr = head_ff;
      end else if (cmd.scan_step) begin
         rd_addr = chk_next;
      end else begin
         rd_addr = chk_prev;
      end
      we = cmd.shift_step || (cmd.finish && stat.push_ok);
      if (cmd.shift_step) begin
         wa         = wr_ptr_ff;
         wd_payload = rd_payload_ff;
         wd_length  = rd_length_ff;
         wd_final   = rd_final_ff;
         wd_seq     = rd_seq_ff;
      end else begin
         wa         = push_idx;
         wd_payload = payload_ff;
         wd_length  = length_ff;
         wd_final   = final_ff;
         wd_seq     = seq_ff;
      end
   end

   // Write and read the slot memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem_payload[wa]  <= wd_payload;
         mem_length[wa]   <= wd_length;
         mem_final[wa]    <= wd_final;
         mem_sequence[wa] <= wd_seq;
      end
      if (rd_en) begin
         rd_payload_ff <= mem_payload[rd_addr];
         rd_length_ff  <= mem_length[rd_addr];
         rd_final_ff   <= mem_final[rd_addr];
         rd_seq_ff     <= mem_sequence[rd_addr];
      end
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_opcode;
         len_ok_ff  <= req_line_length < speq_pkg::LENGTH_W'(LINE_LIMIT);
         payload_ff <= req_payload;
         length_ff  <= req_line_length[LEN_W-1:0];
         final_ff   <= req_final_flag;
         seq_ff     <= req_sequence_req;
      end
   end

   // Advance walk pointers
   always_comb begin
      chk_ptr_in = chk_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      k_in       = k_ff;
      evict_in   = evict_ff;
      if (cmd.latch) begin
         evict_in = 1'b0;
      end
      if (cmd.scan_start) begin
         chk_ptr_in = head_ff;
         k_in       = '0;
         evict_in   = 1'b1;
      end else if (cmd.scan_step) begin
         chk_ptr_in = chk_next;
         k_in       = k_ff + 1'b1;
      end else if (cmd.shift_start || cmd.shift_step) begin
         wr_ptr_in  = chk_ptr_ff;
         chk_ptr_in = chk_prev;
      end
   end

   // Apply the finished item to the queue and load the result
   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      gen_in           = gen_ff;
      last_seq_in      = last_seq_ff;
      have_last_in     = have_last_ff;
      drop_in          = drop_ff;
      reject_in        = reject_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_payload_in   = rsp_payload_ff;
      rsp_length_in    = rsp_length_ff;
      rsp_final_in     = rsp_final_ff;
      rsp_seq_in       = rsp_seq_ff;
      rsp_evicted_in   = rsp_evicted_ff;
      rsp_discarded_in = rsp_discarded_ff;
      rsp_occupancy_in = rsp_occupancy_ff;
      rsp_gen_in       = rsp_gen_ff;
      rsp_drop_in      = rsp_drop_ff;
      rsp_reject_in    = rsp_reject_ff;
      if (cmd.finish) begin
         rsp_valid_in     = 1'b1;
         rsp_status_in    = speq_pkg::ST_OK;
         rsp_payload_in   = '0;
         rsp_length_in    = '0;
         rsp_final_in     = 1'b0;
         rsp_seq_in       = '0;
         rsp_evicted_in   = 1'b0;
         rsp_discarded_in = '0;
         case (op_ff)
            speq_pkg::OP_PUSH: begin
               if (!len_ok_ff) begin
                  rsp_status_in = speq_pkg::ST_LEN_REJECT;
               end else if (evict_ff) begin
                  // shed one and append: count stays at full
                  head_in        = head_next;
                  drop_in        = drop_ff + 1'b1;
                  rsp_evicted_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            speq_pkg::OP_POP: begin
               if (count_ff == '0) begin
                  rsp_status_in = speq_pkg::ST_EMPTY;
               end else begin
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
                  if (have_last_ff && (rd_seq_ff <= last_seq_ff)) begin
                     reject_in     = reject_ff + 1'b1;
                     rsp_status_in = speq_pkg::ST_OLD_SEQ;
                  end else begin
                     last_seq_in    = rd_seq_ff;
                     have_last_in   = 1'b1;
                     rsp_payload_in = rd_payload_ff;
                     rsp_length_in  = speq_pkg::LENGTH_W'(rd_length_ff);
                     rsp_final_in   = rd_final_ff;
                     rsp_seq_in     = rd_seq_ff;
                  end
               end
            end
            speq_pkg::OP_INVALIDATE: begin
               gen_in           = gen_ff + 1'b1;
               have_last_in     = 1'b0;
               last_seq_in      = '0;
               rsp_discarded_in = speq_pkg::COUNT_W'(count_ff);
               drop_in          = drop_ff + speq_pkg::TOTAL_W'(count_ff);
               head_in          = '0;
               count_in         = '0;
            end
            default: begin
            end
         endcase
         rsp_occupancy_in = speq_pkg::COUNT_W'(count_in);
         rsp_gen_in       = gen_in;
         rsp_drop_in      = drop_in;
         rsp_reject_in    = reject_in;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         gen_ff       <= '0;
         last_seq_ff  <= '0;
         have_last_ff <= 1'b0;
         drop_ff      <= '0;
         reject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         evict_ff     <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
         last_seq_ff  <= last_seq_in;
         have_last_ff <= have_last_in;
         drop_ff      <= drop_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
         evict_ff     <= evict_in;
      end
   end

   // Hold walk pointers and result payload
   always_ff @(posedge clock) begin
      chk_ptr_ff       <= chk_ptr_in;
      wr_ptr_ff        <= wr_ptr_in;
      k_ff             <= k_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_payload_ff   <= rsp_payload_in;
      rsp_length_ff    <= rsp_length_in;
      rsp_final_ff     <= rsp_final_in;
      rsp_seq_ff       <= rsp_seq_in;
      rsp_evicted_ff   <= rsp_evicted_in;
      rsp_discarded_ff <= rsp_discarded_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_gen_ff       <= rsp_gen_in;
      rsp_drop_ff      <= rsp_drop_in;
      rsp_reject_ff    <= rsp_reject_in;
   end

   // Drive the result channel
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_payload    = rsp_payload_ff;
   assign rsp_out_length     = rsp_length_ff;
   assign rsp_out_final      = rsp_final_ff;
   assign rsp_out_sequence   = rsp_seq_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_discarded      = rsp_discarded_ff;
   assign rsp_occupancy      = rsp_occupancy_ff;
   assign rsp_generation     = rsp_gen_ff;
   assign rsp_dropped_total  = rsp_drop_ff;
   assign rsp_rejected_total = rsp_reject_ff;

endmodule

/* src/shed_partial_first_event_queue_top.sv */
// Top level of the shed-partial-first event queue.
//
// Request channel (req_*): one command per transfer: push an event, pop the
// head event, or invalidate the session. Result channel (rsp_*): exactly one
// result per request, in request order, held in an output register.
// A push into a non-full queue, a pop, an invalidate or a rejected request
// passes through the dispatch and finish states only. A push into a full
// queue walks the slot memory one entry a cycle from the head to find the
// oldest partial entry, then moves each older entry up one slot, one a cycle,
// and sheds the partial entry; if none is found it sheds the head entry.
// The slot memory has a single read port; one request is in work at a time.
// req_ready is high only while no request is in work; a new request can be
// taken while the previous result still waits in the output register.
// Reset empties the queue and clears the generation, sequence history and
// totals; slot contents are not cleared and no clearing pass runs.
// If the receiver stalls, the finished result is held and the next request
// completes its work and then waits until the output register is free.
`include "shed_partial_first_event_queue_top_defines.svh"

module shed_partial_first_event_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int LINE_LIMIT  = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_opcode,
   input  logic [speq_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [speq_pkg::LENGTH_W-1:0]  req_line_length,
   input  logic                           req_final_flag,
   input  logic [speq_pkg::SEQ_W-1:0]     req_sequence_req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [speq_pkg::PAYLOAD_W-1:0] rsp_out_payload,
   output logic [speq_pkg::LENGTH_W-1:0]  rsp_out_length,
   output logic                           rsp_out_final,
   output logic [speq_pkg::SEQ_W-1:0]     rsp_out_sequence,
   output logic                           rsp_evicted,
   output logic [speq_pkg::COUNT_W-1:0]   rsp_discarded,
   output logic [speq_pkg::COUNT_W-1:0]   rsp_occupancy,
   output logic [speq_pkg::TOTAL_W-1:0]   rsp_generation,
   output logic [speq_pkg::TOTAL_W-1:0]   rsp_dropped_total,
   output logic [speq_pkg::TOTAL_W-1:0]   rsp_rejected_total
);

   speq_pkg::cmd_type  cmd;
   speq_pkg::stat_type stat;

   // Sequence each request
   speq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store slots, counters and the result
   speq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LINE_LIMIT  (LINE_LIMIT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_payload        (req_payload),
      .req_line_length    (req_line_length),
      .req_final_flag     (req_final_flag),
      .req_sequence_req   (req_sequence_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_final      (rsp_out_final),
      .rsp_out_sequence   (rsp_out_sequence),
      .rsp_evicted        (rsp_evicted),
      .rsp_discarded      (rsp_discarded),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_generation     (rsp_generation),
      .rsp_dropped_total  (rsp_dropped_total),
      .rsp_rejected_total (rsp_rejected_total)
   );

   // Only one request is in work at a time
   `SPEQ_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   // A shedding push leaves the queue full
   `SPEQ_ASSERT_SAME(a_evict_full, clock, reset, rsp_valid && rsp_evicted, rsp_occupancy == speq_pkg::COUNT_W'(QUEUE_DEPTH))
   // An invalidate that discards entries leaves the queue empty
   `SPEQ_ASSERT_SAME(a_discard_empty, clock, reset, rsp_valid && (rsp_discarded != '0), rsp_occupancy == '0)
   // Popped fields are zero unless a pop succeeded
   `SPEQ_ASSERT_SAME(a_fields_zero, clock, reset, rsp_valid && (rsp_status != speq_pkg::ST_OK), (rsp_out_payload == '0) && (rsp_out_sequence == '0))

endmodule
